// ===== src/nlmsp_pkg.sv =====
package nlmsp_pkg;

   localparam int HIST_W   = 8;
   localparam int WEIGHT_W = 24;
   localparam int BASE_W   = 16;
   localparam int U_W      = 17;
   localparam int UMAG_W   = 16;
   localparam int WU_W     = WEIGHT_W + U_W;
   localparam int UU_W     = 2 * UMAG_W;
   localparam int MU_W     = 17;
   localparam int ME_W     = MU_W + WEIGHT_W;
   localparam int PR3_W    = ME_W + UMAG_W;
   localparam int QUO_W    = 26;

   localparam logic [1:0] MODE_MEAN   = 2'd0;
   localparam logic [1:0] MODE_DIRECT = 2'd1;
   localparam logic [1:0] MODE_DIFF   = 2'd2;

   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_RATE   = 2'd1;
   localparam logic [1:0] REG_WINDOW = 2'd2;

   localparam logic [1:0]      MODE_RESET = 2'd0;
   localparam logic [MU_W-1:0] RATE_RESET = 17'd26214;
   localparam logic [3:0]      WIN_RESET  = 4'd5;
   localparam logic [MU_W-1:0] MU_ONE     = 17'h10000;

   localparam logic signed [WEIGHT_W-1:0] Q24_MAX = 24'sh7FFFFF;
   localparam logic signed [WEIGHT_W-1:0] Q24_MIN = 24'sh800000;

   typedef struct packed {
      logic rotate;
      logic push;
   } cell_ctl_type;

endpackage

// ===== src/nlmsp_cell.sv =====
module nlmsp_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  nlmsp_pkg::cell_ctl_type           ctl,
   input  logic [nlmsp_pkg::HIST_W-1:0]      nbr_hist,
   input  logic [nlmsp_pkg::WEIGHT_W-1:0]    nbr_weight,
   input  logic [nlmsp_pkg::HIST_W-1:0]      prev_hist,
   output logic [nlmsp_pkg::HIST_W-1:0]      hist,
   output logic [nlmsp_pkg::WEIGHT_W-1:0]    weight
);
   import nlmsp_pkg::*;

   logic [HIST_W-1:0]   hist_ff;
   logic [WEIGHT_W-1:0] weight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff   <= '0;
         weight_ff <= '0;
      end else if (ctl.rotate) begin
         hist_ff   <= nbr_hist;
         weight_ff <= nbr_weight;
      end else if (ctl.push) begin
         hist_ff <= prev_hist;
      end
   end

   assign hist   = hist_ff;
   assign weight = weight_ff;

endmodule

// ===== src/nlmsp_div.sv =====
module nlmsp_div #(
   parameter int NUM_W = 58,
   parameter int DEN_W = 44,
   parameter int QUO_W = 26
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [QUO_W-1:0] quo
);
   localparam int HI_W  = NUM_W - QUO_W;
   localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;
   localparam int CNT_W = $clog2(QUO_W);

   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [QUO_W-1:0] qn_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [HI_W-1:0]  hi;
   logic             ovf;
   logic [DEN_W:0]   trial;
   logic             ge;

   assign hi    = num[NUM_W-1:QUO_W];
   assign ovf   = CMP_W'(hi) >= CMP_W'(den);
   assign trial = {rem_ff, qn_ff[QUO_W-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= start ? ovf : (busy_ff && (cnt_ff == CNT_W'(QUO_W - 1)));
         if (start) begin
            den_ff <= den;
            cnt_ff <= '0;
            if (ovf) begin
               qn_ff <= '1;
            end else begin
               rem_ff  <= DEN_W'(hi);
               qn_ff   <= num[QUO_W-1:0];
               busy_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            rem_ff <= ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
            qn_ff  <= {qn_ff[QUO_W-2:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QUO_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = qn_ff;

endmodule

// ===== src/nlms_predictor_three_variants.sv =====
// a sample can wait on the output register before its weights update; each tap's update
// runs through the divider, which local-mean mode shares to form the mean
// the first sample after reset gives no result; one sample at a time
// the result sits in an output register, so the next sample is taken while it waits
// reset is synchronous: history, weights, sample count and registers go to defaults
module nlms_predictor_three_variants #(
   parameter int WINDOW = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [23:0] rsp_predicted,
   output logic signed [23:0] rsp_error,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import nlmsp_pkg::*;

   localparam int HD     = WINDOW + 1;
   localparam int CNT_W  = $clog2(HD);
   localparam int LEN_W  = $clog2(HD + 1);
   localparam int SUM_W  = HIST_W + LEN_W;
   localparam int ACC_W  = WU_W + LEN_W;
   localparam int NORM_W = UU_W + LEN_W;
   localparam int DEN_W  = NORM_W + 8;
   localparam int NUM_W  = ((PR3_W > NORM_W + 7) ? PR3_W : NORM_W + 7) + 1;
   localparam int PF_W   = ACC_W + 2;

   typedef enum logic [3:0] {
      S_IDLE, S_SUM, S_MSTART, S_MWAIT, S_DOT, S_DRAIN, S_PRED, S_ERR,
      S_OUT, S_UMUL, S_USTART, S_UWAIT, S_UWR, S_PUSH
   } state_type;

   function automatic logic signed [WEIGHT_W-1:0] sat24(input logic signed [63:0] v);
      if (v > 64'(Q24_MAX)) return Q24_MAX;
      if (v < 64'(Q24_MIN)) return Q24_MIN;
      return v[WEIGHT_W-1:0];
   endfunction

   state_type state_ff;
   logic [1:0]       cfg_mode_ff;
   logic [MU_W-1:0]  cfg_rate_ff;
   logic [3:0]       cfg_win_ff;

   logic [LEN_W-1:0] seen_ff;
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] taps_ff;
   logic [CNT_W-1:0] p_ff;
   logic [1:0]       mode_ff;
   logic [HIST_W-1:0] x_ff;
   logic [HIST_W-1:0] h0_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [BASE_W-1:0] base_ff;
   logic signed [WU_W-1:0]   wu_ff;
   logic [UU_W-1:0]          uu_ff;
   logic                     pv_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [NORM_W-1:0]        norm_ff;
   logic signed [WEIGHT_W-1:0] pred_ff;
   logic signed [WEIGHT_W-1:0] err_ff;
   logic [ME_W-1:0]          me_ff;
   logic [PR3_W-1:0]         pr3_ff;
   logic                     neg_ff;
   logic                     rsp_valid_ff;
   logic signed [WEIGHT_W-1:0] rsp_pred_ff;
   logic signed [WEIGHT_W-1:0] rsp_err_ff;

   logic [HIST_W-1:0]   cell_hist [HD];
   logic [WEIGHT_W-1:0] cell_wt [HD];
   logic [WEIGHT_W-1:0] feed_wt;
   cell_ctl_type        cell_ctl;

   logic [LEN_W-1:0] w_use;
   logic [LEN_W-1:0] len_new;
   logic [LEN_W-1:0] p_ext;
   logic             tap_act;
   logic             last_pos;
   logic signed [U_W:0]   u_wide;
   logic signed [U_W-1:0] u_val;
   logic [UMAG_W-1:0]     u_mag;
   logic signed [WU_W-1:0] wu_prod;
   logic [UU_W-1:0]       uu_prod;
   logic [ACC_W-1:0]      acc_mag;
   logic [ACC_W:0]        acc_rnd;
   logic signed [PF_W-1:0] pred_full;
   logic signed [WEIGHT_W:0] err_full;
   logic [WEIGHT_W-1:0]   err_mag;
   logic [MU_W-1:0]       mu_c;
   logic [NORM_W-1:0]     norm_eff;
   logic signed [WEIGHT_W+3:0] delta;
   logic signed [WEIGHT_W+3:0] wsum;
   logic signed [WEIGHT_W-1:0] new_wt;
   logic             div_start;
   logic             div_done;
   logic [NUM_W-1:0] div_num;
   logic [DEN_W-1:0] div_den;
   logic [QUO_W-1:0] div_quo;
   logic             csr_wr;
   logic [1:0]       csr_idx;

   // cell ring: rotation moves toward cell 0, push moves history away from it
   for (genvar k = 0; k < HD; k++) begin : g_cell
      logic [HIST_W-1:0]   nh;
      logic [WEIGHT_W-1:0] nw;
      logic [HIST_W-1:0]   ph;
      if (k == HD - 1) begin : g_tail
         assign nh = cell_hist[0];
         assign nw = feed_wt;
      end else begin : g_mid
         assign nh = cell_hist[k+1];
         assign nw = cell_wt[k+1];
      end
      if (k == 0) begin : g_head
         assign ph = x_ff;
      end else begin : g_rest
         assign ph = cell_hist[k-1];
      end
      nlmsp_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .nbr_hist   (nh),
         .nbr_weight (nw),
         .prev_hist  (ph),
         .hist       (cell_hist[k]),
         .weight     (cell_wt[k])
      );
   end

   assign p_ext    = LEN_W'(p_ff);
   assign tap_act  = p_ext < taps_ff;
   assign last_pos = p_ff == CNT_W'(HD - 1);

   always_comb begin
      w_use = ({28'b0, cfg_win_ff} > 32'(WINDOW)) ? LEN_W'(WINDOW) : LEN_W'(cfg_win_ff);
      len_new = (seen_ff > w_use) ? w_use + 1'b1 : seen_ff;
   end

   always_comb begin
      case (mode_ff)
         MODE_MEAN:   u_wide = $signed({2'b0, cell_hist[0], 8'b0}) - $signed({2'b0, base_ff});
         MODE_DIRECT: u_wide = $signed({2'b0, h0_ff, 8'b0}) - $signed({2'b0, cell_hist[1], 8'b0});
         default:     u_wide = $signed({2'b0, cell_hist[0], 8'b0})
                               - $signed({2'b0, cell_hist[1], 8'b0});
      endcase
      u_val   = u_wide[U_W-1:0];
      u_mag   = u_val[U_W-1] ? UMAG_W'(-u_val) : UMAG_W'(u_val);
      wu_prod = $signed({{U_W{cell_wt[0][WEIGHT_W-1]}}, cell_wt[0]})
              * $signed({{WEIGHT_W{u_val[U_W-1]}}, u_val});
      uu_prod = {{UMAG_W{1'b0}}, u_mag} * {{UMAG_W{1'b0}}, u_mag};
   end

   always_comb begin
      acc_mag   = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      acc_rnd   = ({1'b0, acc_mag} + (ACC_W+1)'(128)) >> 8;
      pred_full = $signed({{(PF_W-BASE_W){1'b0}}, base_ff})
                + (acc_ff[ACC_W-1] ? -$signed({1'b0, acc_rnd}) : $signed({1'b0, acc_rnd}));
      err_full  = $signed({{(WEIGHT_W-HIST_W-8+1){1'b0}}, x_ff, 8'b0})
                - $signed({pred_ff[WEIGHT_W-1], pred_ff});
      err_mag   = err_ff[WEIGHT_W-1] ? WEIGHT_W'(-err_ff) : WEIGHT_W'(err_ff);
      mu_c      = (cfg_rate_ff > MU_ONE) ? MU_ONE : cfg_rate_ff;
      norm_eff  = (norm_ff == '0) ? NORM_W'(32'h10000) : norm_ff;
      delta     = neg_ff ? -$signed({2'b0, div_quo}) : $signed({2'b0, div_quo});
      wsum      = $signed({{4{cell_wt[0][WEIGHT_W-1]}}, cell_wt[0]}) + delta;
      new_wt    = sat24(64'(wsum));
   end

   always_comb begin
      if (state_ff == S_MSTART) begin
         div_num = NUM_W'({sum_ff, 8'b0}) + NUM_W'(len_ff >> 1);
         div_den = DEN_W'(len_ff);
      end else begin
         div_num = NUM_W'(pr3_ff) + NUM_W'({norm_eff, 7'b0});
         div_den = DEN_W'({norm_eff, 8'b0});
      end
   end

   assign div_start = (state_ff == S_MSTART) || (state_ff == S_USTART);

   nlmsp_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .QUO_W (QUO_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      cell_ctl.rotate = (state_ff == S_SUM) || (state_ff == S_DOT) || (state_ff == S_UWR)
                      || ((state_ff == S_UMUL) && !tap_act);
      cell_ctl.push   = state_ff == S_PUSH;
      feed_wt = (state_ff == S_UWR) ? new_wt : cell_wt[0];
   end

   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cfg_mode_ff  <= MODE_RESET;
         cfg_rate_ff  <= RATE_RESET;
         cfg_win_ff   <= WIN_RESET;
         seen_ff      <= '0;
         p_ff         <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            case (csr_idx)
               REG_MODE:   cfg_mode_ff <= csr_pwdata[1:0];
               REG_RATE:   cfg_rate_ff <= csr_pwdata[MU_W-1:0];
               REG_WINDOW: cfg_win_ff  <= csr_pwdata[3:0];
               default:    ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && (state_ff != S_OUT)) rsp_valid_ff <= 1'b0;
         if (pv_ff) begin
            acc_ff  <= acc_ff + ACC_W'(wu_ff);
            norm_ff <= norm_ff + NORM_W'(uu_ff);
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  x_ff    <= req_sample;
                  h0_ff   <= cell_hist[0];
                  p_ff    <= '0;
                  sum_ff  <= '0;
                  acc_ff  <= '0;
                  norm_ff <= '0;
                  pv_ff   <= 1'b0;
                  len_ff  <= len_new;
                  taps_ff <= len_new - 1'b1;
                  mode_ff <= (cfg_mode_ff == MODE_MEAN || cfg_mode_ff == MODE_DIRECT)
                             ? cfg_mode_ff : MODE_DIFF;
                  base_ff <= {cell_hist[0], 8'b0};
                  if (seen_ff == '0) state_ff <= S_PUSH;
                  else if (cfg_mode_ff == MODE_MEAN) state_ff <= S_SUM;
                  else state_ff <= S_DOT;
               end
            end
            S_SUM: begin
               if (p_ext < len_ff) sum_ff <= sum_ff + SUM_W'(cell_hist[0]);
               p_ff <= last_pos ? '0 : p_ff + 1'b1;
               if (last_pos) state_ff <= S_MSTART;
            end
            S_MSTART: state_ff <= S_MWAIT;
            S_MWAIT: begin
               if (div_done) begin
                  base_ff  <= div_quo[BASE_W-1:0];
                  state_ff <= S_DOT;
               end
            end
            S_DOT: begin
               wu_ff <= wu_prod;
               uu_ff <= uu_prod;
               pv_ff <= tap_act;
               p_ff  <= last_pos ? '0 : p_ff + 1'b1;
               if (last_pos) state_ff <= S_DRAIN;
            end
            S_DRAIN: begin
               pv_ff    <= 1'b0;
               state_ff <= S_PRED;
            end
            S_PRED: begin
               pred_ff  <= sat24(64'(pred_full));
               state_ff <= S_ERR;
            end
            S_ERR: begin
               err_ff   <= sat24(64'(err_full));
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_pred_ff  <= pred_ff;
                  rsp_err_ff   <= err_ff;
                  me_ff        <= {{WEIGHT_W{1'b0}}, mu_c} * {{MU_W{1'b0}}, err_mag};
                  p_ff         <= '0;
                  state_ff     <= S_UMUL;
               end
            end
            S_UMUL: begin
               if (tap_act) begin
                  pr3_ff   <= {{UMAG_W{1'b0}}, me_ff} * {{ME_W{1'b0}}, u_mag};
                  neg_ff   <= err_ff[WEIGHT_W-1] ^ u_val[U_W-1];
                  state_ff <= S_USTART;
               end else begin
                  p_ff <= last_pos ? '0 : p_ff + 1'b1;
                  if (last_pos) state_ff <= S_PUSH;
               end
            end
            S_USTART: state_ff <= S_UWAIT;
            S_UWAIT: begin
               if (div_done) state_ff <= S_UWR;
            end
            S_UWR: begin
               p_ff     <= last_pos ? '0 : p_ff + 1'b1;
               state_ff <= last_pos ? S_PUSH : S_UMUL;
            end
            S_PUSH: begin
               if (seen_ff != LEN_W'(HD)) seen_ff <= seen_ff + 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_MODE:   csr_prdata = {30'b0, cfg_mode_ff};
         REG_RATE:   csr_prdata = {15'b0, cfg_rate_ff};
         REG_WINDOW: csr_prdata = {28'b0, cfg_win_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign csr_pready    = 1'b1;
   assign req_ready     = state_ff == S_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_predicted = rsp_pred_ff;
   assign rsp_error     = rsp_err_ff;

endmodule

// ===== src/nlmsp_checker.sv =====
module nlmsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] rsp_predicted,
   input logic [23:0] rsp_error,
   input logic        csr_pready
);

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");

   a_reset: assert property (@(posedge clock) reset |=> (!rsp_valid && req_ready))
      else $error("bad state after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second beat taken while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_predicted) && $stable(rsp_error)))
      else $error("stalled result beat changed");

endmodule

bind nlms_predictor_three_variants nlmsp_checker u_nlmsp_checker (.*);

// ===== dv/tb_nlms_predictor_three_variants.sv =====
module tb_nlms_predictor_three_variants;
   import nlmsp_pkg::*;

   localparam int TAPS_MAX = 8;
   localparam int SETTLE_CYCLES = 400;
   localparam logic [1:0] MODE_ALIAS = 2'd3;
   localparam logic [1:0] REG_NONE = 2'd3;

   typedef struct packed {
      logic signed [23:0] predicted;
      logic signed [23:0] error;
   } prediction_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_sample;
   logic        rsp_valid;
   logic        rsp_ready;
   logic signed [23:0] rsp_predicted;
   logic signed [23:0] rsp_error;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor state
   logic [7:0]  hist [TAPS_MAX+1];
   longint      weights [TAPS_MAX];
   int          seen;
   logic [1:0]  cur_mode;
   logic [16:0] cur_rate;
   logic [3:0]  cur_window;

   prediction_type pending_q [$];
   int          mismatches;
   int          samples_sent;
   int          results_checked;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          recv_hold;
   logic [7:0]  walk;

   nlms_predictor_three_variants u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_predicted(rsp_predicted), .rsp_error(rsp_error),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20 * 3000000);
      $display("timeout");
      $display("FAIL");
      $finish;
   end

   function automatic longint div_nearest(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint sat24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   task automatic push_history(input logic [7:0] x);
      for (int i = TAPS_MAX; i > 0; i--) hist[i] = hist[i-1];
      hist[0] = x;
   endtask

   task automatic predict_sample(input logic [7:0] x);
      int w_use, len, taps, m;
      longint base, acc, norm, pred, err, mu, sum;
      longint u [TAPS_MAX];
      prediction_type p;
      acc = 0;
      norm = 0;
      if (seen == 0) begin
         push_history(x);
         seen = 1;
         return;
      end
      w_use = (cur_window > TAPS_MAX) ? TAPS_MAX : cur_window;
      len = (seen > w_use) ? w_use + 1 : seen;
      if (len > TAPS_MAX + 1) len = TAPS_MAX + 1;
      taps = len - 1;
      m = (cur_mode > MODE_DIFF) ? MODE_DIFF : cur_mode;
      if (m == MODE_MEAN) begin
         sum = 0;
         for (int i = 0; i < len; i++) sum += hist[i];
         base = div_nearest(sum * 256, len);
      end else begin
         base = longint'(hist[0]) * 256;
      end
      for (int i = 0; i < taps; i++) begin
         if (m == MODE_MEAN) u[i] = longint'(hist[i]) * 256 - base;
         else if (m == MODE_DIRECT) u[i] = (longint'(hist[0]) - longint'(hist[i+1])) * 256;
         else u[i] = (longint'(hist[i]) - longint'(hist[i+1])) * 256;
         acc += weights[i] * u[i];
         norm += u[i] * u[i];
      end
      pred = sat24(base + div_nearest(acc, 256));
      err = sat24(longint'(x) * 256 - pred);
      if (norm == 0) norm = 65536;
      mu = (cur_rate > MU_ONE) ? MU_ONE : cur_rate;
      for (int i = 0; i < taps; i++)
         weights[i] = sat24(weights[i] + div_nearest(mu * err * u[i], norm * 256));
      push_history(x);
      if (seen < TAPS_MAX + 1) seen++;
      p.predicted = pred[23:0];
      p.error = err[23:0];
      pending_q.push_back(p);
   endtask

   task automatic report_mismatch(input string what, input logic [23:0] got,
                                  input logic [23:0] want);
      $display("mismatch on %s: got %0d expected %0d (result %0d)", what,
               $signed(got), $signed(want), results_checked);
      mismatches++;
   endtask

   always @(posedge clock) begin
      prediction_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_q.size() == 0) begin
            report_mismatch("unexpected result beat", rsp_predicted, 24'd0);
         end else begin
            want = pending_q.pop_front();
            if (rsp_predicted !== want.predicted)
               report_mismatch("predicted", rsp_predicted, want.predicted);
            if (rsp_error !== want.error)
               report_mismatch("error", rsp_error, want.error);
         end
         results_checked++;
      end
   end

   always @(negedge clock) begin
      if (recv_hold > 0) begin
         rsp_ready <= 1'b0;
         recv_hold <= recv_hold - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_sample(input logic [7:0] x);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= x;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_sample(x);
      samples_sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_MODE: cur_mode = value[1:0];
         REG_RATE: cur_rate = value[16:0];
         REG_WINDOW: cur_window = value[3:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic configure(input logic [1:0] m, input logic [16:0] rate, input logic [3:0] win);
      settle();
      write_reg(REG_MODE, 32'(m));
      write_reg(REG_RATE, 32'(rate));
      write_reg(REG_WINDOW, 32'(win));
   endtask

   function automatic logic [7:0] next_sample();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) walk = walk + 8'($urandom_range(10)) - 8'd5;
      else if (pick < 75) walk = 8'($urandom_range(255));
      else if (pick < 88) walk = (pick[0]) ? 8'd0 : 8'd255;
      else walk = walk ^ 8'($urandom_range(255));
      return walk;
   endfunction

   task automatic test_directed();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_sample(8'd0);
      send_sample(8'd255);
      send_sample(8'd0);
      send_sample(8'd255);
      configure(MODE_MEAN, 17'd65536, 4'd8);
      repeat (4) send_sample(8'd255);
      send_sample(8'd0);
      configure(MODE_DIRECT, 17'd0, 4'd1);
      send_sample(8'd17);
      send_sample(8'd200);
      send_sample(8'd3);
      configure(MODE_DIFF, 17'h1FFFF, 4'd15);
      for (int i = 0; i < 5; i++) send_sample((i % 2) ? 8'd255 : 8'd0);
      configure(MODE_ALIAS, 17'd1, 4'd0);
      send_sample(8'd128);
      send_sample(8'd1);
      settle();
      write_reg(REG_NONE, 32'hFFFF_FFFF);
      send_sample(8'd77);
      send_sample(8'd254);
   endtask

   task automatic test_random(input int n, input int s_pct, input int r_pct);
      logic [1:0] m;
      logic [16:0] rate;
      logic [3:0] win;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) begin
            m = 2'($urandom_range(3));
            rate = ($urandom_range(3) == 0) ? 17'($urandom_range(131071))
                                             : 17'($urandom_range(65536));
            win = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
            configure(m, rate, win);
         end
         send_sample(next_sample());
      end
   endtask

   task automatic test_backpressure();
      settle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      @(negedge clock);
      recv_hold = 3000;
      for (int i = 0; i < 12; i++) send_sample(next_sample());
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = 8'd0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = 4'd0;
      csr_pwdata = 32'd0;
      mismatches = 0;
      samples_sent = 0;
      results_checked = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      recv_hold = 0;
      walk = 8'd128;
      seen = 0;
      cur_mode = MODE_RESET;
      cur_rate = RATE_RESET;
      cur_window = WIN_RESET;
      for (int i = 0; i <= TAPS_MAX; i++) hist[i] = 8'd0;
      for (int i = 0; i < TAPS_MAX; i++) weights[i] = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(220, 11, 59);
      test_random(220, 59, 11);
      test_random(220, 0, 0);
      test_backpressure();

      settle();
      $display("covered %0d samples and %0d checked results over all modes,", samples_sent,
               results_checked);
      $display("window and step size extremes, idle patterns and a long output stall");
      if (mismatches == 0 && pending_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
